// File: rtl/mcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, symbol codes and the Morse lookup for the decoder.
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam logic [7:0] SymDot   = 8'h2E;
  localparam logic [7:0] SymDash  = 8'h2D;
  localparam logic [7:0] SymSpace = 8'h20;
  localparam logic [7:0] SymSep   = 8'h5F;
  localparam logic [7:0] CharNone = 8'h00;

  localparam logic [2:0] LenSat = 3'd7;

  localparam int FifoDepth = 2;
  localparam int PtrW      = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW      = $clog2(FifoDepth + 1);

  // one closed token on its way from front to back
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] bits;
    logic       space_seen;
    logic       other_seen;
  } token_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       bad;
  } result_t;

  // dot/dash pattern lookup, dash = 1, first symbol in the highest used bit
  function automatic logic [7:0] lookup(input logic [2:0] len, input logic [5:0] bits);
    logic [7:0] ch;
    ch = CharNone;
    case ({len, bits})
      {3'd1, 6'b000000}: ch = "e";
      {3'd1, 6'b000001}: ch = "t";
      {3'd2, 6'b000001}: ch = "a";
      {3'd2, 6'b000000}: ch = "i";
      {3'd2, 6'b000011}: ch = "m";
      {3'd2, 6'b000010}: ch = "n";
      {3'd3, 6'b000100}: ch = "d";
      {3'd3, 6'b000110}: ch = "g";
      {3'd3, 6'b000101}: ch = "k";
      {3'd3, 6'b000111}: ch = "o";
      {3'd3, 6'b000010}: ch = "r";
      {3'd3, 6'b000000}: ch = "s";
      {3'd3, 6'b000001}: ch = "u";
      {3'd3, 6'b000011}: ch = "w";
      {3'd4, 6'b001000}: ch = "b";
      {3'd4, 6'b001010}: ch = "c";
      {3'd4, 6'b000010}: ch = "f";
      {3'd4, 6'b000000}: ch = "h";
      {3'd4, 6'b000111}: ch = "j";
      {3'd4, 6'b000100}: ch = "l";
      {3'd4, 6'b000110}: ch = "p";
      {3'd4, 6'b001101}: ch = "q";
      {3'd4, 6'b000001}: ch = "v";
      {3'd4, 6'b001001}: ch = "x";
      {3'd4, 6'b001011}: ch = "y";
      {3'd4, 6'b001100}: ch = "z";
      {3'd5, 6'b001111}: ch = "1";
      {3'd5, 6'b000111}: ch = "2";
      {3'd5, 6'b000011}: ch = "3";
      {3'd5, 6'b000001}: ch = "4";
      {3'd5, 6'b000000}: ch = "5";
      {3'd5, 6'b010000}: ch = "6";
      {3'd5, 6'b011000}: ch = "7";
      {3'd5, 6'b011100}: ch = "8";
      {3'd5, 6'b011110}: ch = "9";
      {3'd5, 6'b011111}: ch = "0";
      {3'd5, 6'b001010}: ch = "+";
      {3'd5, 6'b010001}: ch = "=";
      {3'd6, 6'b010101}: ch = ".";
      {3'd6, 6'b110011}: ch = ",";
      {3'd6, 6'b001100}: ch = "?";
      {3'd6, 6'b100001}: ch = "-";
      {3'd6, 6'b101010}: ch = ";";
      {3'd6, 6'b111000}: ch = ":";
      default:           ch = CharNone;
    endcase
    return ch;
  endfunction

  function automatic result_t decode(input token_t tok);
    result_t r;
    r.ch = CharNone;
    if (tok.len == 3'd0 || tok.len == LenSat || tok.other_seen) begin
      r.ch = CharNone;
    end else if (tok.space_seen) begin
      r.ch = (tok.len == 3'd1) ? SymSpace : CharNone;
    end else begin
      r.ch = lookup(tok.len, tok.bits);
    end
    r.bad = (r.ch == CharNone);
    return r;
  endfunction

endpackage

// File: rtl/mcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_front
// Accepts stream bytes, builds the current token and hands closed tokens on.
// ----------------------------------------------------------------------------
module mcd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        sym,
  input  logic              line_end,
  output logic              tok_push,
  output mcd_pkg::token_t   tok_data
);

  mcd_pkg::token_t tok;
  mcd_pkg::token_t tok_next;
  logic            closing;

  assign closing  = line_end ? (tok.len != 3'd0) : (sym == mcd_pkg::SymSep);
  assign tok_push = accept && closing;
  assign tok_data = tok;

  always_comb begin
    tok_next = tok;
    if (accept) begin
      if (closing) begin
        tok_next = '0;
      end else if (!line_end) begin
        if (tok.len != mcd_pkg::LenSat) begin
          tok_next.len = tok.len + 3'd1;
        end
        if (sym == mcd_pkg::SymDot || sym == mcd_pkg::SymDash) begin
          tok_next.bits = {tok.bits[4:0], (sym == mcd_pkg::SymDash)};
        end else if (sym == mcd_pkg::SymSpace) begin
          tok_next.space_seen = 1'b1;
        end else begin
          tok_next.other_seen = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

// File: rtl/mcd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_fifo
// Short token queue between front and back.
// ----------------------------------------------------------------------------
module mcd_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  mcd_pkg::token_t            wr_data,
  input  logic                       rd_en,
  output mcd_pkg::token_t            rd_data,
  output logic                       not_empty,
  output logic                       is_full,
  output logic [mcd_pkg::CntW-1:0]   count
);

  mcd_pkg::token_t             mem [mcd_pkg::FifoDepth];
  logic [mcd_pkg::PtrW-1:0]    wr_ptr;
  logic [mcd_pkg::PtrW-1:0]    rd_ptr;

  assign not_empty = (count != '0);
  assign is_full   = (count == mcd_pkg::CntW'(mcd_pkg::FifoDepth));
  assign rd_data   = mem[rd_ptr];

  function automatic logic [mcd_pkg::PtrW-1:0] bump(input logic [mcd_pkg::PtrW-1:0] p);
    return (p == mcd_pkg::PtrW'(mcd_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/mcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_back
// Decodes queued tokens through the Morse table into the result register.
// ----------------------------------------------------------------------------
module mcd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_valid,
  input  mcd_pkg::token_t   tok_data,
  output logic              tok_take,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        char_out,
  output logic              bad_token
);

  logic             valid;
  mcd_pkg::result_t res;
  logic             slot_free;

  assign slot_free = !valid || pop;
  assign tok_take  = tok_valid && slot_free;
  assign res       = mcd_pkg::decode(tok_data);
  assign empty     = !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (slot_free) begin
      valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take) begin
      char_out  <= res.ch;
      bad_token <= res.bad;
    end
  end

endmodule

// File: rtl/morse_code_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_decoder_core
// Morse symbol stream to ASCII characters, one result per closed token.
//
//   channel   ports                       request moves when
//   input     push full sym line_end      push && !full
//   result    empty pop char_out bad_token pop && !empty
//
// One byte per cycle is accepted while full is low. The accepted byte that closes
// a token writes it into the token queue; from the queue head the table lookup
// feeds the result register once the result slot is free or is being popped.
// Synchronous reset clears the pending token, the queue and the result slot.
// While results are not taken the two-entry queue fills and full rises.
// ----------------------------------------------------------------------------
module morse_code_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] sym,
  input  logic       line_end,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] char_out,
  output logic       bad_token
);

  logic                      accept;
  logic                      tok_push;
  mcd_pkg::token_t           tok_in;
  mcd_pkg::token_t           tok_head;
  logic                      tok_valid;
  logic                      tok_take;
  logic [mcd_pkg::CntW-1:0]  fifo_count;

  assign accept = push && !full;

  mcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sym      (sym),
    .line_end (line_end),
    .tok_push (tok_push),
    .tok_data (tok_in)
  );

  mcd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (tok_push),
    .wr_data   (tok_in),
    .rd_en     (tok_take),
    .rd_data   (tok_head),
    .not_empty (tok_valid),
    .is_full   (full),
    .count     (fifo_count)
  );

  mcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_data  (tok_head),
    .tok_take  (tok_take),
    .pop       (pop),
    .empty     (empty),
    .char_out  (char_out),
    .bad_token (bad_token)
  );

  // queue occupancy never passes its depth
  assert property (@(posedge clk) disable iff (rst)
    fifo_count <= mcd_pkg::CntW'(mcd_pkg::FifoDepth))
    else $error("token queue overflow");

  // a flagged result carries no character
  assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_token) |-> (char_out == mcd_pkg::CharNone))
    else $error("bad token with nonzero character");

  // an accepted separator leaves a token queued or a result waiting
  assert property (@(posedge clk) disable iff (rst)
    (accept && !line_end && sym == mcd_pkg::SymSep) |=> (tok_valid || !empty))
    else $error("separator produced no token");

  // a result slot that is not popped keeps its value
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(bad_token)))
    else $error("waiting result changed");

endmodule
